// File: sv/address_region_table_macros.svh
// Assertion macros for the address region table.
// Each check is clocked on clk and is disabled while arst_n is low.
`ifndef ADDRESS_REGION_TABLE_MACROS_SVH
`define ADDRESS_REGION_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define ART_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("address_region_table: same-cycle check failed");
`define ART_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("address_region_table: next-cycle check failed");
`else
`define ART_ASSERT_NOW(lbl, pre, post)
`define ART_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: sv/art_pkg.sv
package art_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int ADDR_BITS_DEF = 48;
	localparam int FIELD_W       = 48;
	localparam int SLOT_OUT_W    = 4;

	// Operation codes carried in the kind field. The fourth code is unused.
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERLAP   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE   = 3'd0,
		SEQ_SCAN   = 3'd1,
		SEQ_LAST   = 3'd2,
		SEQ_COMMIT = 3'd3,
		SEQ_OUT    = 3'd4
	} seq_state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] region_base;
		logic [FIELD_W-1:0] region_size;
		logic [FIELD_W-1:0] query_address;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [FIELD_W-1:0]    found_base;
		logic [FIELD_W-1:0]    found_size;
		logic [SLOT_OUT_W-1:0] found_slot;
	} rsp_t;

endpackage

// File: sv/address_region_table.sv
// Each item scans the whole table, one table slot per cycle through the single read port
// of the table memory. No new item is taken until the result of the last one has been taken.
// Reset: arst_n clears the sequencer, the scan flags and every slot valid bit at once.
// Stored bases and sizes are not cleared; a slot's base and size count only while its valid bit is set.
`include "address_region_table_macros.svh"

module address_region_table #(
	parameter int ENTRIES   = art_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = art_pkg::ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  art_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output art_pkg::rsp_t rsp
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

	typedef logic [ADDR_BITS-1:0] addr_t;

	// Sequencer state.
	art_pkg::seq_state_t state_q, state_d;
	logic [SLOT_W-1:0]   idx_q;

	// The accepted item, reduced to the address width of the table.
	logic [1:0] kind_q;
	addr_t      base_q, size_q, addr_q, end_q;
	logic       invalid_q;

	// Scan stage: one table slot read per cycle, compared in the following cycle.
	logic              step_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;
	addr_t             mbase_s1, msize_s1;

	// Flags gathered over the scan.
	logic              overlap_q, free_found_q, hit_q;
	logic [SLOT_W-1:0] free_q, hit_slot_q;
	addr_t             hit_base_q, hit_size_q;

	// Table storage: valid bits in flops, base and size in a memory.
	logic [ENTRIES-1:0] vld_q;
	addr_t              mem_base [ENTRIES];
	addr_t              mem_size [ENTRIES];

	art_pkg::rsp_t rsp_q;

	logic    accept;
	addr_t   in_base, in_size, in_addr, in_end;
	logic    in_invalid;
	addr_t   m_end;
	logic    hit_ovl, hit_rem, hit_lkp, match;
	logic    commit, do_ins, do_rem;
	art_pkg::status_t status_d;
	logic [SLOT_W-1:0] slot_d;
	addr_t   fbase_d, fsize_d;

	// Input side. Addresses are taken modulo the address space; a region is
	// refused up front when it is empty or its end does not land above its base.
	assign accept     = req_valid && !req_stall;
	assign in_base    = ADDR_BITS'(req.region_base);
	assign in_size    = ADDR_BITS'(req.region_size);
	assign in_addr    = ADDR_BITS'(req.query_address);
	assign in_end     = in_base + in_size;
	assign in_invalid = (in_size == '0) || (in_end <= in_base);

	// The shared compare unit. Stored regions never wrap, so the end of a
	// stored region is a plain sum and containment is a pair of compares.
	assign m_end   = mbase_s1 + msize_s1;
	assign hit_ovl = vld_s1 && (base_q < m_end) && (mbase_s1 < end_q);
	assign hit_rem = vld_s1 && (mbase_s1 == base_q);
	assign hit_lkp = vld_s1 && (addr_q >= mbase_s1) && (addr_q < m_end);
	assign match   = (kind_q == art_pkg::KIND_REMOVE) ? hit_rem : hit_lkp;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			art_pkg::SEQ_IDLE: begin
				if (accept) begin
					state_d = art_pkg::SEQ_SCAN;
				end
			end
			art_pkg::SEQ_SCAN: begin
				if (idx_q == LAST_SLOT) begin
					state_d = art_pkg::SEQ_LAST;
				end
			end
			art_pkg::SEQ_LAST: begin
				state_d = art_pkg::SEQ_COMMIT;
			end
			art_pkg::SEQ_COMMIT: begin
				state_d = art_pkg::SEQ_OUT;
			end
			art_pkg::SEQ_OUT: begin
				if (!rsp_stall) begin
					state_d = art_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = art_pkg::SEQ_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: handshakes and the decision taken once the
	// whole table has been scanned. Insert checks run in the order invalid,
	// overlap, full; failed items leave the table untouched.
	always_comb begin
		req_stall = (state_q != art_pkg::SEQ_IDLE);
		rsp_valid = (state_q == art_pkg::SEQ_OUT);
		commit    = (state_q == art_pkg::SEQ_COMMIT);
		status_d  = art_pkg::ST_INVALID;
		slot_d    = '0;
		fbase_d   = '0;
		fsize_d   = '0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		unique case (kind_q)
			art_pkg::KIND_INSERT: begin
				if (invalid_q) begin
					status_d = art_pkg::ST_INVALID;
				end else if (overlap_q) begin
					status_d = art_pkg::ST_OVERLAP;
				end else if (!free_found_q) begin
					status_d = art_pkg::ST_FULL;
				end else begin
					status_d = art_pkg::ST_OK;
					slot_d   = free_q;
					do_ins   = commit;
				end
			end
			art_pkg::KIND_REMOVE: begin
				if (hit_q) begin
					status_d = art_pkg::ST_OK;
					slot_d   = hit_slot_q;
					do_rem   = commit;
				end else begin
					status_d = art_pkg::ST_NOT_FOUND;
				end
			end
			art_pkg::KIND_LOOKUP: begin
				if (hit_q) begin
					status_d = art_pkg::ST_OK;
					slot_d   = hit_slot_q;
					fbase_d  = hit_base_q;
					fsize_d  = hit_size_q;
				end else begin
					status_d = art_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = art_pkg::ST_INVALID;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= art_pkg::SEQ_IDLE;
			idx_q        <= '0;
			step_s1      <= 1'b0;
			overlap_q    <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			vld_q        <= '0;
		end else begin
			state_q <= state_d;
			step_s1 <= (state_q == art_pkg::SEQ_SCAN);
			if (accept) begin
				idx_q        <= '0;
				overlap_q    <= 1'b0;
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end else begin
				if (state_q == art_pkg::SEQ_SCAN && idx_q != LAST_SLOT) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
				if (step_s1) begin
					if (hit_ovl) begin
						overlap_q <= 1'b1;
					end
					if (!vld_s1 && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (match && !hit_q) begin
						hit_q <= 1'b1;
					end
				end
			end
			if (do_ins) begin
				vld_q[free_q] <= 1'b1;
			end
			if (do_rem) begin
				vld_q[hit_slot_q] <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			base_q    <= in_base;
			size_q    <= in_size;
			addr_q    <= in_addr;
			end_q     <= in_end;
			invalid_q <= in_invalid;
		end
		idx_s1 <= idx_q;
		vld_s1 <= vld_q[idx_q];
		if (step_s1) begin
			if (!vld_s1 && !free_found_q) begin
				free_q <= idx_s1;
			end
			if (match && !hit_q) begin
				hit_slot_q <= idx_s1;
				hit_base_q <= mbase_s1;
				hit_size_q <= msize_s1;
			end
		end
		if (commit) begin
			rsp_q.status     <= status_d;
			rsp_q.found_base <= art_pkg::FIELD_W'(fbase_d);
			rsp_q.found_size <= art_pkg::FIELD_W'(fsize_d);
			rsp_q.found_slot <= art_pkg::SLOT_OUT_W'(slot_d);
		end
	end

	// Table memory: one write port for inserts, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (do_ins) begin
			mem_base[free_q] <= base_q;
			mem_size[free_q] <= size_q;
		end
		mbase_s1 <= mem_base[idx_q];
		msize_s1 <= mem_size[idx_q];
	end

	assign rsp = rsp_q;

	// An accepted item always starts its scan at the first slot.
	`ART_ASSERT_NEXT(a_accept_starts_scan, accept, (state_q == art_pkg::SEQ_SCAN) && (idx_q == '0))
	// A successful insert leaves its slot marked valid while the result is shown.
	`ART_ASSERT_NOW(a_insert_sets_valid, rsp_valid && (rsp.status == art_pkg::ST_OK) && (kind_q == art_pkg::KIND_INSERT), vld_q[free_q])
	// A successful remove leaves its slot free while the result is shown.
	`ART_ASSERT_NOW(a_remove_clears_valid, rsp_valid && (rsp.status == art_pkg::ST_OK) && (kind_q == art_pkg::KIND_REMOVE), !vld_q[hit_slot_q])
	// A refused or not-found item changes no valid bit.
	`ART_ASSERT_NEXT(a_fail_keeps_table, commit && (status_d != art_pkg::ST_OK), $stable(vld_q))

endmodule

// File: bench/region_table_checker.sv
module region_table_checker #(
	parameter int SLOTS = art_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  art_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  art_pkg::rsp_t rsp,
	output int unsigned   mismatches,
	output int unsigned   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                        slot_used  [SLOTS];
	logic [art_pkg::FIELD_W-1:0] slot_start [SLOTS];
	logic [art_pkg::FIELD_W-1:0] slot_len   [SLOTS];
	art_pkg::rsp_t               pending_answers [$];
	int unsigned                 fail_total = 0;

	assign mismatches = fail_total;

	// Applies one item to the shadow table and returns the answer it must produce.
	function automatic art_pkg::rsp_t table_answer(input art_pkg::req_t item);
		art_pkg::rsp_t             ans;
		logic [art_pkg::FIELD_W:0] end_new;
		logic [art_pkg::FIELD_W:0] end_old;
		int                        free_idx;
		logic                      clash;
		ans      = '0;
		free_idx = -1;
		clash    = 1'b0;
		end_new  = {1'b0, item.region_base} + {1'b0, item.region_size};
		case (item.kind)
			art_pkg::KIND_INSERT: begin
				// A region that wraps or ends exactly at the top of the space is refused.
				if (item.region_size == '0
						|| end_new[art_pkg::FIELD_W-1:0] <= item.region_base) begin
					ans.status = art_pkg::ST_INVALID;
				end else begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_used[i]) begin
							end_old = {1'b0, slot_start[i]} + {1'b0, slot_len[i]};
							if ({1'b0, item.region_base} < end_old
									&& {1'b0, slot_start[i]} < end_new) begin
								clash = 1'b1;
							end
						end else if (free_idx < 0) begin
							free_idx = i;
						end
					end
					if (clash) begin
						ans.status = art_pkg::ST_OVERLAP;
					end else if (free_idx < 0) begin
						ans.status = art_pkg::ST_FULL;
					end else begin
						slot_used[free_idx]  = 1'b1;
						slot_start[free_idx] = item.region_base;
						slot_len[free_idx]   = item.region_size;
						ans.status           = art_pkg::ST_OK;
						ans.found_slot       = free_idx[art_pkg::SLOT_OUT_W-1:0];
					end
				end
			end
			art_pkg::KIND_REMOVE: begin
				ans.status = art_pkg::ST_NOT_FOUND;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i] && slot_start[i] == item.region_base) begin
						slot_used[i]   = 1'b0;
						ans.status     = art_pkg::ST_OK;
						ans.found_slot = i[art_pkg::SLOT_OUT_W-1:0];
						break;
					end
				end
			end
			art_pkg::KIND_LOOKUP: begin
				ans.status = art_pkg::ST_NOT_FOUND;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i] && item.query_address >= slot_start[i]
							&& (item.query_address - slot_start[i]) < slot_len[i]) begin
						ans.status     = art_pkg::ST_OK;
						ans.found_base = slot_start[i];
						ans.found_size = slot_len[i];
						ans.found_slot = i[art_pkg::SLOT_OUT_W-1:0];
						break;
					end
				end
			end
			default: begin
				ans.status = art_pkg::ST_INVALID;
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		art_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i] = 1'b0;
			end
			pending_answers.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					$error("result item arrived while no item was outstanding");
					fail_total++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_total++;
					end
					if (rsp.found_base !== want.found_base) begin
						$error("found_base: expected 'h%0h, got 'h%0h",
							want.found_base, rsp.found_base);
						fail_total++;
					end
					if (rsp.found_size !== want.found_size) begin
						$error("found_size: expected 'h%0h, got 'h%0h",
							want.found_size, rsp.found_size);
						fail_total++;
					end
					if (rsp.found_slot !== want.found_slot) begin
						$error("found_slot: expected %0d, got %0d",
							want.found_slot, rsp.found_slot);
						fail_total++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				pending_answers.push_back(table_answer(req));
			end
			outstanding <= pending_answers.size();
		end
	end

endmodule

// File: bench/tb_address_region_table.sv
module tb_address_region_table;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [art_pkg::FIELD_W-1:0] field_t;

	// The package names only the three real operations; the fourth code must still be sent.
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam field_t     ADDR_TOP     = '1;
	localparam int         RANDOM_ITEMS = 1400;
	// From this item on neither side idles, so the tail of the run goes at full rate.
	localparam int         QUIET_FROM   = 1200;
	// Idle clocks waited after the last result, before the run is judged.
	localparam int         DRAIN_CYCLES = 40;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	art_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	art_pkg::rsp_t rsp;
	int unsigned   mismatches;
	int unsigned   outstanding;

	// How much both sides idle: 0 never, 1 now and then, 2 often.
	int unsigned idle_level = 1;
	// Most random regions land in a 16 KiB window so that inserts, removes and
	// lookups keep hitting each other instead of spreading over the whole space.
	field_t      window = '0;
	// Bases of recent inserts, reused by removes and lookups so that they find things.
	field_t      recent_bases [$];

	always #5 clk = ~clk;

	address_region_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	region_table_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic field_t random_address();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[art_pkg::FIELD_W-1:0];
	endfunction

	function automatic art_pkg::req_t make_item(input logic [1:0] kind, input field_t base,
			input field_t size, input field_t addr);
		art_pkg::req_t item;
		item.kind          = kind;
		item.region_base   = base;
		item.region_size   = size;
		item.query_address = addr;
		return item;
	endfunction

	// Presents one item, possibly after an idle burst, and returns at the clock edge
	// where the block took it. The payload is held steady while the block stalls.
	task automatic send_item(input art_pkg::req_t item);
		int unsigned chance;
		chance = (idle_level == 2) ? 2 : 6;
		if (idle_level != 0 && $urandom_range(1, chance) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (item.kind == art_pkg::KIND_INSERT) begin
			recent_bases.push_back(item.region_base);
			if (recent_bases.size() > 24) begin
				void'(recent_bases.pop_front());
			end
		end
	endtask

	// Holds the sender back until every item in flight has given its result.
	// The first edge is skipped because the checker's count is registered and lags the accepting edge.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// One random item. Runs of 120 items alternate between filling the table and
	// emptying it, so that both the full table and the nearly empty one are seen often.
	// A few items are pure noise: any kind, with every field drawn from the whole range.
	task automatic next_random_item(input int n, output art_pkg::req_t item);
		int unsigned pick;
		int unsigned insert_pct;
		int unsigned remove_pct;
		field_t      anchor;
		if ((n / 120) % 2 == 0) begin
			insert_pct = 55;
			remove_pct = 15;
		end else begin
			insert_pct = 20;
			remove_pct = 45;
		end
		anchor = (recent_bases.size() > 0)
			? recent_bases[$urandom_range(0, recent_bases.size() - 1)] : window;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			item = make_item(2'($urandom_range(0, 3)), random_address(), random_address(),
				random_address());
		end else if (pick < 6 + insert_pct) begin
			// Near the top of the space some of these wrap or end exactly at the top.
			item = make_item(art_pkg::KIND_INSERT, window + $urandom_range(0, 16'h3FFF),
				field_t'($urandom_range(1, 1024)), random_address());
		end else if (pick < 6 + insert_pct + remove_pct) begin
			item = make_item(art_pkg::KIND_REMOVE,
				($urandom_range(0, 3) != 0) ? anchor : window + $urandom_range(0, 16'h3FFF),
				random_address(), random_address());
		end else begin
			item = make_item(art_pkg::KIND_LOOKUP, random_address(), random_address(),
				($urandom_range(0, 4) < 3) ? anchor + $urandom_range(0, 1100)
					: window + $urandom_range(0, 18000));
		end
	endtask

	initial begin : stimulus
		art_pkg::req_t item;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty table finds nothing.
		send_item(make_item(art_pkg::KIND_LOOKUP, '0, '0, '0));
		send_item(make_item(art_pkg::KIND_REMOVE, '0, '0, '0));
		// Invalid regions: zero size, a region ending exactly at the top of the
		// space, and one that wraps far past it.
		send_item(make_item(art_pkg::KIND_INSERT, 48'h1000, '0, '0));
		send_item(make_item(art_pkg::KIND_INSERT, ADDR_TOP, 48'h1, '0));
		send_item(make_item(art_pkg::KIND_INSERT, ADDR_TOP, ADDR_TOP, '0));
		// The largest region that fits covers everything but the last byte.
		send_item(make_item(art_pkg::KIND_INSERT, '0, ADDR_TOP, '0));
		send_item(make_item(art_pkg::KIND_LOOKUP, '0, '0, ADDR_TOP - 1));
		send_item(make_item(art_pkg::KIND_LOOKUP, '0, '0, ADDR_TOP));
		send_item(make_item(art_pkg::KIND_INSERT, ADDR_TOP - 1, 48'h1, '0));
		// The unused operation code changes nothing and answers invalid.
		send_item(make_item(KIND_UNUSED, ADDR_TOP, ADDR_TOP, ADDR_TOP));
		send_item(make_item(art_pkg::KIND_REMOVE, 48'h1, '0, '0));
		send_item(make_item(art_pkg::KIND_REMOVE, '0, '0, '0));
		// The last byte that a region can cover now becomes a region of its own in slot 0.
		send_item(make_item(art_pkg::KIND_INSERT, ADDR_TOP - 1, 48'h1, '0));
		// Fill the remaining slots with regions that touch but do not overlap.
		for (int i = 0; i < 15; i++) begin
			send_item(make_item(art_pkg::KIND_INSERT, 48'h100 * i, 48'h100, '0));
		end
		// A full table refuses a free region, but an overlap is reported ahead of that.
		send_item(make_item(art_pkg::KIND_INSERT, 48'h10000, 48'h1, '0));
		send_item(make_item(art_pkg::KIND_INSERT, 48'h80, 48'h1, '0));
		// Removal needs the exact base; an address inside a region is not enough.
		send_item(make_item(art_pkg::KIND_REMOVE, 48'h180, '0, '0));
		// Region ends are exclusive.
		send_item(make_item(art_pkg::KIND_LOOKUP, '0, '0, 48'h100));
		send_item(make_item(art_pkg::KIND_LOOKUP, '0, '0, 48'hF00));
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				idle_level = (n >= QUIET_FROM) ? 0 : $urandom_range(0, 2);
			end
			if (n % 150 == 0) begin
				case ($urandom_range(0, 3))
					0: window = '0;
					1: window = ADDR_TOP - 48'h3FFF;
					default: window = random_address() & ~48'hFFFF;
				endcase
			end
			if (n % 350 == 349) begin
				wait_drained();
			end
			next_random_item(n, item);
			send_item(item);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// The result side stalls in bursts at the same level of idling as the sender.
	initial begin : result_side
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_level != 0 && $urandom_range(1, (idle_level == 2) ? 3 : 8) == 1) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// A correct run needs well under a millisecond, even with the heaviest idling.
	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
